/* sv/bffa_pkg.sv */
// Package for the bitmap first-fit allocator: field widths, codes, state type
// and the command and status words between controller and datapath.
// No dependencies.
package bffa_pkg;

  localparam int NUM_GRANULES_DEF = 512;
  localparam int GRANULE_BYTES    = 8;
  localparam int GRAN_SHIFT       = 3;   // log2 of GRANULE_BYTES
  localparam int ROW_G            = 8;   // granules held in one map row
  localparam int ROW_SHIFT        = 3;   // log2 of ROW_G

  localparam int LEN_W   = 13;
  localparam int OFFS_W  = 12;
  localparam int NEED_W  = LEN_W + 1 - GRAN_SHIFT;
  localparam int FIRST_W = OFFS_W - GRAN_SHIFT;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SRCH,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic prep;
    logic srch_step;
    logic upd_rd;
    logic upd_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_zero;
    logic need_big;
    logic is_free;
    logic free_out;
    logic found;
    logic srch_end;
    logic upd_last;
  } dp_stat_t;

endpackage

/* sv/bffa_ctrl.sv */
// Controller of the bitmap first-fit allocator: sequences the clearing pass,
// the search and the read-modify-write marking. Uses bffa_pkg.
module bffa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output logic                  out_valid,
  output bffa_pkg::ctrl_cmd_t   cmd,
  input  bffa_pkg::dp_stat_t    stat
);

  bffa_pkg::state_t state_r;
  bffa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    busy      = 1'b1;
    case (state_r)
      bffa_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = bffa_pkg::ST_IDLE;
      end
      bffa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = bffa_pkg::ST_DECIDE;
        end
      end
      bffa_pkg::ST_DECIDE: begin
        cmd.prep = 1'b1;
        if (stat.need_zero) begin
          state_nxt = bffa_pkg::ST_RESP;
        end else if (!stat.is_free) begin
          state_nxt = stat.need_big ? bffa_pkg::ST_RESP : bffa_pkg::ST_SRCH;
        end else begin
          state_nxt = stat.free_out ? bffa_pkg::ST_RESP : bffa_pkg::ST_UPD_RD;
        end
      end
      bffa_pkg::ST_SRCH: begin
        cmd.srch_step = 1'b1;
        if (stat.found) begin
          state_nxt = bffa_pkg::ST_UPD_RD;
        end else if (stat.srch_end) begin
          state_nxt = bffa_pkg::ST_RESP;
        end
      end
      bffa_pkg::ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = bffa_pkg::ST_UPD_WR;
      end
      bffa_pkg::ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = stat.upd_last ? bffa_pkg::ST_RESP : bffa_pkg::ST_UPD_RD;
      end
      bffa_pkg::ST_RESP: begin
        out_valid = 1'b1;
        state_nxt = bffa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  // An accepted word keeps the block busy until its result has been shown.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not hold the block busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block not idle after a result");

endmodule

/* sv/bffa_dp.sv */
// Datapath of the bitmap first-fit allocator: the used map memory (eight
// granules a row), the run counter, the range registers and the result.
// Uses bffa_pkg; driven by bffa_ctrl.
module bffa_dp #(
  parameter int NUM_GRANULES = bffa_pkg::NUM_GRANULES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_command,
  input  logic [bffa_pkg::LEN_W-1:0]    in_length_bytes,
  input  logic [bffa_pkg::OFFS_W-1:0]   in_free_offset,
  input  bffa_pkg::ctrl_cmd_t           cmd,
  output bffa_pkg::dp_stat_t            stat,
  output logic                          res_status,
  output logic [bffa_pkg::OFFS_W-1:0]   res_offset
);

  localparam int NUM_ROWS = (NUM_GRANULES + bffa_pkg::ROW_G - 1) / bffa_pkg::ROW_G;
  localparam int AW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int GI_W     = AW + bffa_pkg::ROW_SHIFT;
  localparam int SUM_W    = ((GI_W > bffa_pkg::OFFS_W) ? GI_W : bffa_pkg::OFFS_W) + 1;
  localparam logic [AW-1:0]    LAST_ROW = AW'(NUM_ROWS - 1);
  localparam logic [SUM_W-1:0] LAST_G   = SUM_W'(NUM_GRANULES - 1);

  // Map memory, one write and one registered read port.
  logic [bffa_pkg::ROW_G-1:0] mem [NUM_ROWS];
  logic [bffa_pkg::ROW_G-1:0] rdata_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bffa_pkg::ROW_G-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  logic                         cmd_r;
  logic [bffa_pkg::NEED_W-1:0]  need_r;
  logic [bffa_pkg::FIRST_W-1:0] first_r;
  logic [AW-1:0]                clr_addr_r;
  logic [AW-1:0]                rd_addr_r;
  logic [AW-1:0]                proc_row_r;
  logic [bffa_pkg::NEED_W-1:0]  run_r;
  logic [GI_W-1:0]              lo_r;
  logic [GI_W-1:0]              hi_r;
  logic [AW-1:0]                upd_row_r;
  logic                         status_r;
  logic [bffa_pkg::OFFS_W-1:0]  offset_r;

  logic [bffa_pkg::LEN_W:0]     len_sum;
  logic [bffa_pkg::NEED_W-1:0]  need_in;
  logic [bffa_pkg::NEED_W-1:0]  run;
  logic                         hit;
  logic [bffa_pkg::ROW_SHIFT-1:0] hit_j;
  logic [GI_W-1:0]              scan_g;
  logic                         scan_used;
  logic [GI_W-1:0]              end_g;
  logic [SUM_W-1:0]             start_sum;
  logic [GI_W-1:0]              start_g;
  logic [31:0]                  start_ext;
  logic [bffa_pkg::OFFS_W-1:0]  offs_calc;
  logic [SUM_W-1:0]             hi_sum;
  logic [SUM_W-1:0]             hi_cl;
  logic [GI_W-1:0]              lo_free;
  logic [GI_W-1:0]              hi_free;
  logic [GI_W-1:0]              upd_g;
  logic                         rd_ok;
  logic                         set_val;

  assign len_sum = {1'b0, in_length_bytes}
                 + (bffa_pkg::LEN_W + 1)'(bffa_pkg::GRANULE_BYTES - 1);
  assign need_in = len_sum[bffa_pkg::LEN_W:bffa_pkg::GRAN_SHIFT];

  // Walk the eight granules of the row in hand; granules past the end of the
  // pool count as used so that no run can reach into them.
  always_comb begin
    run   = run_r;
    hit   = 1'b0;
    hit_j = '0;
    scan_g = '0;
    scan_used = 1'b0;
    for (int j = 0; j < bffa_pkg::ROW_G; j++) begin
      scan_g    = {proc_row_r, bffa_pkg::ROW_SHIFT'(j)};
      scan_used = rdata_r[j] || (SUM_W'(scan_g) > LAST_G);
      run       = scan_used ? '0 : run + bffa_pkg::NEED_W'(1);
      if (!hit && (run == need_r)) begin
        hit   = 1'b1;
        hit_j = bffa_pkg::ROW_SHIFT'(j);
      end
    end
  end

  assign end_g     = {proc_row_r, hit_j};
  assign start_sum = SUM_W'(end_g) + SUM_W'(1) - SUM_W'(need_r);
  assign start_g   = start_sum[GI_W-1:0];
  assign start_ext = 32'(start_g);
  assign offs_calc = {start_ext[bffa_pkg::OFFS_W-bffa_pkg::GRAN_SHIFT-1:0],
                      bffa_pkg::GRAN_SHIFT'(0)};

  // Free range, clipped at the last granule of the pool.
  assign hi_sum  = SUM_W'(first_r) + SUM_W'(need_r) - SUM_W'(1);
  assign hi_cl   = (hi_sum > LAST_G) ? LAST_G : hi_sum;
  assign hi_free = hi_cl[GI_W-1:0];
  assign lo_free = GI_W'(first_r);

  assign rd_ok   = (rd_addr_r <= LAST_ROW);
  assign set_val = (cmd_r == bffa_pkg::CMD_ALLOC);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd.prep) begin
      mem_re = 1'b1;
    end else if (cmd.srch_step) begin
      mem_re    = rd_ok;
      mem_raddr = rd_addr_r;
    end else if (cmd.upd_rd) begin
      mem_re    = 1'b1;
      mem_raddr = upd_row_r;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    upd_g     = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.upd_wr) begin
      mem_we    = 1'b1;
      mem_waddr = upd_row_r;
      for (int j = 0; j < bffa_pkg::ROW_G; j++) begin
        upd_g        = {upd_row_r, bffa_pkg::ROW_SHIFT'(j)};
        mem_wdata[j] = ((upd_g >= lo_r) && (upd_g <= hi_r)) ? set_val : rdata_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      need_r   <= need_in;
      first_r  <= in_free_offset[bffa_pkg::OFFS_W-1:bffa_pkg::GRAN_SHIFT];
      status_r <= bffa_pkg::STATUS_OK;
      offset_r <= '0;
    end else if (cmd.prep) begin
      rd_addr_r  <= AW'(1);
      proc_row_r <= '0;
      run_r      <= '0;
      lo_r       <= lo_free;
      hi_r       <= hi_free;
      upd_row_r  <= lo_free[GI_W-1:bffa_pkg::ROW_SHIFT];
      if (!stat.is_free && stat.need_big && !stat.need_zero) begin
        status_r <= bffa_pkg::STATUS_NOSPACE;
      end
    end else if (cmd.srch_step) begin
      rd_addr_r  <= rd_addr_r + AW'(1);
      proc_row_r <= proc_row_r + AW'(1);
      run_r      <= run;
      if (hit) begin
        lo_r      <= start_g;
        hi_r      <= end_g;
        upd_row_r <= start_g[GI_W-1:bffa_pkg::ROW_SHIFT];
        offset_r  <= offs_calc;
      end else if (proc_row_r == LAST_ROW) begin
        status_r <= bffa_pkg::STATUS_NOSPACE;
      end
    end else if (cmd.upd_wr) begin
      upd_row_r <= upd_row_r + AW'(1);
    end
  end

  always_comb begin
    stat.clr_last  = (clr_addr_r == LAST_ROW);
    stat.need_zero = (need_r == '0);
    stat.need_big  = (32'(need_r) > 32'(NUM_GRANULES));
    stat.is_free   = (cmd_r == bffa_pkg::CMD_FREE);
    stat.free_out  = (32'(first_r) >= 32'(NUM_GRANULES));
    stat.found     = hit;
    stat.srch_end  = !hit && (proc_row_r == LAST_ROW);
    stat.upd_last  = (upd_row_r == hi_r[GI_W-1:bffa_pkg::ROW_SHIFT]);
  end

  assign res_status = status_r;
  assign res_offset = offset_r;

  // The search streams rows out of the map, so nothing may be written meanwhile.
  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_step |-> !mem_we)
    else $error("map written during the search");

  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_wr |-> ((upd_row_r >= lo_r[GI_W-1:bffa_pkg::ROW_SHIFT]) &&
                    (upd_row_r <= hi_r[GI_W-1:bffa_pkg::ROW_SHIFT])))
    else $error("map row written outside the run");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.srch_step && hit) |=>
      ((status_r == bffa_pkg::STATUS_OK) &&
       (upd_row_r == lo_r[GI_W-1:bffa_pkg::ROW_SHIFT])))
    else $error("found run not set up for marking");

endmodule

/* sv/bitmap_first_fit_allocator_unit.sv */
// Top level of the bitmap first-fit allocator: controller plus datapath.
// Depends on bffa_pkg, bffa_ctrl and bffa_dp.
//
// A word is taken when start is high and busy is low; its result appears on
// out_status and out_alloc_offset for exactly one cycle with out_valid high,
// and must be captured then, since the receiver cannot hold it off. After
// reset the block clears its map one row of eight granules a cycle, with
// busy high. An allocate scans the map rows in order until the run is found
// or the last row is passed; the first-fit scan reads one map row per cycle
// through the map memory's read port, and marking is a read-modify-write of
// each row the run touches. A free marks the rows it touches the same way.
// A zero length, an allocate longer than the pool or a free beyond the pool
// answers without scan or marking. Busy falls in the cycle after the result.
module bitmap_first_fit_allocator_unit #(
  parameter int NUM_GRANULES = bffa_pkg::NUM_GRANULES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [bffa_pkg::LEN_W-1:0]   in_length_bytes,
  input  logic [bffa_pkg::OFFS_W-1:0]  in_free_offset,
  output logic                         out_valid,
  output logic                         out_status,
  output logic [bffa_pkg::OFFS_W-1:0]  out_alloc_offset
);

  bffa_pkg::ctrl_cmd_t cmd;
  bffa_pkg::dp_stat_t  stat;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  bffa_dp #(
    .NUM_GRANULES (NUM_GRANULES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_length_bytes (in_length_bytes),
    .in_free_offset  (in_free_offset),
    .cmd             (cmd),
    .stat            (stat),
    .res_status      (out_status),
    .res_offset      (out_alloc_offset)
  );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for bitmap_first_fit_allocator_unit: directed and
// random allocate and free words, with every result checked against a granule map predictor.
// Depends on bffa_pkg and the allocator RTL.
module tb_top;

  localparam int NUM_GRANULES = bffa_pkg::NUM_GRANULES_DEF;
  localparam int RANDOM_WORDS = 1000;

  typedef struct {
    logic                        status;
    logic [bffa_pkg::OFFS_W-1:0] offset;
  } reply_t;

  typedef struct {
    logic [bffa_pkg::OFFS_W-1:0] offset;
    logic [bffa_pkg::LEN_W-1:0]  length;
  } grant_t;

  // Keeps its own copy of the granule map and the replies still owed by the block.
  class alloc_scoreboard_t;
    logic [NUM_GRANULES-1:0]     pool_map;
    reply_t                      pending_replies[$];
    int                          error_count;
    logic                        predicted_status;
    logic [bffa_pkg::OFFS_W-1:0] predicted_offset;

    function new();
      pool_map    = '0;
      error_count = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function void note_request(logic cmd, logic [bffa_pkg::LEN_W-1:0] len,
                               logic [bffa_pkg::OFFS_W-1:0] off);
      int     need;
      int     run;
      int     first;
      reply_t reply;
      need         = (int'(len) + bffa_pkg::GRANULE_BYTES - 1) / bffa_pkg::GRANULE_BYTES;
      reply.status = bffa_pkg::STATUS_OK;
      reply.offset = '0;
      if (cmd == bffa_pkg::CMD_ALLOC) begin
        if (need != 0) begin
          reply.status = bffa_pkg::STATUS_NOSPACE;
          run          = 0;
          if (need <= NUM_GRANULES) begin
            for (int i = 0; i < NUM_GRANULES; i++) begin
              run = pool_map[i] ? 0 : run + 1;
              if (run == need) begin
                first = i + 1 - need;
                for (int k = first; k <= i; k++) pool_map[k] = 1'b1;
                reply.status = bffa_pkg::STATUS_OK;
                reply.offset = bffa_pkg::OFFS_W'(first * bffa_pkg::GRANULE_BYTES);
                break;
              end
            end
          end
        end
      end else begin
        // Granules that fall past the end of the pool are simply dropped.
        first = int'(off) >> bffa_pkg::GRAN_SHIFT;
        for (int k = 0; k < need; k++) begin
          if (first + k >= NUM_GRANULES) break;
          pool_map[first + k] = 1'b0;
        end
      end
      predicted_status = reply.status;
      predicted_offset = reply.offset;
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic status, logic [bffa_pkg::OFFS_W-1:0] offset);
      reply_t owed;
      if (pending_replies.size() == 0) begin
        $error("result with no word outstanding: status %0d, alloc_offset %0d",
               status, offset);
        error_count++;
        return;
      end
      owed = pending_replies.pop_front();
      if (status !== owed.status) begin
        $error("status mismatch: expected %0d, actual %0d", owed.status, status);
        error_count++;
      end
      if (offset !== owed.offset) begin
        $error("alloc_offset mismatch: expected %0d, actual %0d", owed.offset, offset);
        error_count++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_command;
  logic [bffa_pkg::LEN_W-1:0]  in_length_bytes;
  logic [bffa_pkg::OFFS_W-1:0] in_free_offset;
  logic                        out_valid;
  logic                        out_status;
  logic [bffa_pkg::OFFS_W-1:0] out_alloc_offset;

  alloc_scoreboard_t sb;
  grant_t            live_grants[$];

  bitmap_first_fit_allocator_unit #(.NUM_GRANULES(NUM_GRANULES)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_length_bytes  (in_length_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Results are checked before a new word is noted, so ordering within the edge is harmless.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_reply(out_status, out_alloc_offset);
      if (start && busy === 1'b0) sb.note_request(in_command, in_length_bytes, in_free_offset);
    end
  end

  initial begin
    #24_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one word once busy is low, so it is taken at the following rising edge.
  task automatic issue_word(logic cmd, logic [bffa_pkg::LEN_W-1:0] len,
                            logic [bffa_pkg::OFFS_W-1:0] off);
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    start           <= 1'b1;
    in_command      <= cmd;
    in_length_bytes <= len;
    in_free_offset  <= off;
    @(negedge clk);
    start           <= 1'b0;
    in_command      <= 1'($urandom);
    in_length_bytes <= bffa_pkg::LEN_W'($urandom);
    in_free_offset  <= bffa_pkg::OFFS_W'($urandom);
  endtask

  task automatic alloc_and_track(logic [bffa_pkg::LEN_W-1:0] len);
    grant_t g;
    issue_word(bffa_pkg::CMD_ALLOC, len, bffa_pkg::OFFS_W'($urandom));
    if (sb.predicted_status == bffa_pkg::STATUS_OK && len != 0) begin
      g.offset = sb.predicted_offset;
      g.length = len;
      live_grants.push_back(g);
    end
  endtask

  task automatic drain_replies();
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic random_word();
    int     pick;
    int     alloc_share;
    int     idx;
    grant_t g;
    logic [bffa_pkg::LEN_W-1:0] len;
    pick        = $urandom_range(0, 99);
    alloc_share = (live_grants.size() > 30) ? 35 : 55;
    if (pick < alloc_share || (live_grants.size() == 0 && pick < 90)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = bffa_pkg::LEN_W'($urandom_range(1, 64));
        6, 7:             len = bffa_pkg::LEN_W'($urandom_range(65, 600));
        8:                len = bffa_pkg::LEN_W'($urandom_range(601, 4096));
        default:          len = bffa_pkg::LEN_W'($urandom_range(0, 8191));
      endcase
      alloc_and_track(len);
    end else if (pick < 90) begin
      // Well-formed free of a run handed out earlier, with junk in the low offset bits.
      idx = $urandom_range(0, live_grants.size() - 1);
      g   = live_grants[idx];
      live_grants.delete(idx);
      issue_word(bffa_pkg::CMD_FREE, g.length,
                 g.offset | bffa_pkg::OFFS_W'($urandom_range(0, 7)));
    end else begin
      len = ($urandom_range(0, 3) == 0) ? bffa_pkg::LEN_W'($urandom_range(0, 8191))
                                        : bffa_pkg::LEN_W'($urandom_range(0, 256));
      issue_word(bffa_pkg::CMD_FREE, len, bffa_pkg::OFFS_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    int burst_left;
    sb              = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = bffa_pkg::CMD_ALLOC;
    in_length_bytes = '0;
    in_free_offset  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    issue_word(bffa_pkg::CMD_ALLOC, 13'd0,    12'd5);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd1,    12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd8,    12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd9,    12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd4097, 12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd8191, 12'hFFF);
    issue_word(bffa_pkg::CMD_FREE,  13'd8,    12'd8);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd8,    12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd8191, 12'd4095);
    issue_word(bffa_pkg::CMD_FREE,  13'd0,    12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd4096, 12'd7);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd4096, 12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd1,    12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd8,    12'd4088);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd8,    12'd0);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd16,   12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd4096, 12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd8,    12'd2048);
    issue_word(bffa_pkg::CMD_ALLOC, 13'd4095, 12'd0);
    issue_word(bffa_pkg::CMD_FREE,  13'd8191, 12'd0);
    drain_replies();

    burst_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      burst_left--;
      if (n % 250 == 125) drain_replies();
      random_word();
    end

    drain_replies();
    repeat (200) @(negedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
